// ===== rtl/fdr_pkg.sv =====
// fdr_pkg: shared types and constants for the fractional divider ratio unit
// holds the sequencer state encoding and the stream port widths
// no dependencies
`timescale 1ns / 1ps

package fdr_pkg;

  localparam int unsigned FreqW      = 32;
  localparam int unsigned SelW       = 3;
  localparam int unsigned CodeW      = 3;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned InUserW    = 3;
  localparam int unsigned OutDataW   = 104;
  localparam int unsigned OutUserW   = 4;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIV_A  = 6'b000010,
    ST_GCD    = 6'b000100,
    ST_GSET   = 6'b001000,
    ST_DIV_BC = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

endpackage

// ===== rtl/fractional_divider_ratio_unit.sv =====
// fractional_divider_ratio_unit: source / target as a + b/c in lowest terms
// one shared subtractor serves a restoring divider and a binary gcd loop
// depends on fdr_pkg
`timescale 1ns / 1ps

// Usage
//   cfg_we_i / cfg_wdata_i write the source frequency (reset 0); write it only
//   while no request is in flight.
//   s_axis takes one request word: tdata = target frequency [31:0], output
//   divider code [34:32]; tuser = output select.
//   m_axis gives one result word per request: tdata = integer part [31:0],
//   numerator [63:32], denominator [95:64], divider code [98:96]; tuser =
//   selected output [2:0], divide error [3].
// Sequencing
//   one request at a time; s_axis_tready is high only while the sequencer is
//   idle. A zero target goes straight to the output register with the divide
//   error set, and an exact division gives the fraction 0/1 after the first
//   division. Otherwise the steps are the first division, the binary gcd,
//   setting up the divisor, two more divisions and the load of the output
//   register; the divisions and the gcd all use one shared subtractor. The
//   next request is taken once the sequencer is back in idle after the load.
// Reset and stalls
//   reset clears the sequencer, the output valid and the source register.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver still stalls when the next result is done, the
//   sequencer holds it until the output register frees up.
module fractional_divider_ratio_unit #(
  parameter int unsigned FREQ_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fdr_pkg::FreqW-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // target_frequency [31:0], output_divider_code [34:32], zero fill
  input  logic [fdr_pkg::InDataW-1:0]   s_axis_tdata,
  // output_select [2:0]
  input  logic [fdr_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // integer_part [31:0], fraction_numerator [63:32],
  // fraction_denominator [95:64], divider_code [98:96], zero fill
  output logic [fdr_pkg::OutDataW-1:0]  m_axis_tdata,
  // selected_output [2:0], divide_error [3]
  output logic [fdr_pkg::OutUserW-1:0]  m_axis_tuser
);

  localparam int unsigned W  = FREQ_BITS;
  localparam int unsigned CW = $clog2(W);

  fdr_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   k_q, k_d;
  logic [W-1:0]    r_q, r_d, q_q, q_d, d_q, d_d;
  logic [W-1:0]    x_q, x_d, y_q, y_d;
  logic [W-1:0]    tgt_q, tgt_d, rem_q, rem_d;
  logic [W-1:0]    a_q, a_d, b_q, b_d, c_q, c_d;
  logic            second_q, second_d;
  logic [fdr_pkg::SelW-1:0]  sel_q, sel_d;
  logic [fdr_pkg::CodeW-1:0] code_q, code_d;
  logic            err_q, err_d;
  logic [fdr_pkg::FreqW-1:0] src_q;

  logic                       out_valid_q, out_valid_d, out_load;
  logic [fdr_pkg::FreqW-1:0]  out_a_q, out_b_q, out_c_q;
  logic [fdr_pkg::SelW-1:0]   out_sel_q;
  logic [fdr_pkg::CodeW-1:0]  out_code_q;
  logic                       out_err_q;

  logic [W-1:0] src_w, tgt_w;
  logic         in_fire;

  // shared subtractor
  logic [W:0]   sub_a, sub_b, sub_diff;
  logic         sub_neg, is_div, x_ge_y;
  logic [W:0]   div_shift;
  logic [W-1:0] r_step, q_step;

  assign src_w   = (W)'(src_q);
  assign tgt_w   = (W)'(s_axis_tdata[31:0]);
  assign s_axis_tready = (state_q == fdr_pkg::ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign is_div    = (state_q == fdr_pkg::ST_DIV_A) || (state_q == fdr_pkg::ST_DIV_BC);
  assign x_ge_y    = (x_q >= y_q);
  assign div_shift = {r_q, q_q[W-1]};

  always_comb begin
    if (is_div) begin
      sub_a = div_shift;
      sub_b = {1'b0, d_q};
    end else if (x_ge_y) begin
      sub_a = {1'b0, x_q};
      sub_b = {1'b0, y_q};
    end else begin
      sub_a = {1'b0, y_q};
      sub_b = {1'b0, x_q};
    end
  end

  assign sub_diff = sub_a - sub_b;
  assign sub_neg  = sub_diff[W];
  assign r_step   = sub_neg ? div_shift[W-1:0] : sub_diff[W-1:0];
  assign q_step   = {q_q[W-2:0], ~sub_neg};

  assign out_load = (state_q == fdr_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    r_d      = r_q;
    q_d      = q_q;
    d_d      = d_q;
    x_d      = x_q;
    y_d      = y_q;
    tgt_d    = tgt_q;
    rem_d    = rem_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    second_d = second_q;
    sel_d    = sel_q;
    code_d   = code_q;
    err_d    = err_q;

    unique case (state_q)
      fdr_pkg::ST_IDLE: begin
        if (in_fire) begin
          sel_d  = s_axis_tuser[2:0];
          code_d = s_axis_tdata[34:32];
          tgt_d  = tgt_w;
          r_d    = '0;
          q_d    = src_w;
          d_d    = tgt_w;
          cnt_d  = CW'(W - 1);
          if (tgt_w == '0) begin
            err_d   = 1'b1;
            a_d     = '0;
            b_d     = '0;
            c_d     = '0;
            state_d = fdr_pkg::ST_FINISH;
          end else begin
            err_d   = 1'b0;
            state_d = fdr_pkg::ST_DIV_A;
          end
        end
      end
      fdr_pkg::ST_DIV_A: begin
        r_d = r_step;
        q_d = q_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          a_d   = q_step;
          rem_d = r_step;
          if (r_step == '0) begin
            // exact division: fraction is 0/1
            b_d     = '0;
            c_d     = W'(1);
            state_d = fdr_pkg::ST_FINISH;
          end else begin
            x_d     = r_step;
            y_d     = tgt_q;
            k_d     = '0;
            state_d = fdr_pkg::ST_GCD;
          end
        end
      end
      fdr_pkg::ST_GCD: begin
        if (x_q == y_q) begin
          state_d = fdr_pkg::ST_GSET;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_ge_y) begin
          x_d = sub_diff[W-1:0] >> 1;
        end else begin
          y_d = sub_diff[W-1:0] >> 1;
        end
      end
      fdr_pkg::ST_GSET: begin
        // divisor is the gcd, odd part restored by the common power of two
        d_d      = x_q << k_q;
        r_d      = '0;
        q_d      = rem_q;
        cnt_d    = CW'(W - 1);
        second_d = 1'b0;
        state_d  = fdr_pkg::ST_DIV_BC;
      end
      fdr_pkg::ST_DIV_BC: begin
        r_d = r_step;
        q_d = q_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (!second_q) begin
            b_d      = q_step;
            r_d      = '0;
            q_d      = tgt_q;
            cnt_d    = CW'(W - 1);
            second_d = 1'b1;
          end else begin
            c_d     = q_step;
            state_d = fdr_pkg::ST_FINISH;
          end
        end
      end
      fdr_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = fdr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdr_pkg::ST_IDLE;
      cnt_q       <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
      src_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        src_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    r_q    <= r_d;
    q_q    <= q_d;
    d_q    <= d_d;
    x_q    <= x_d;
    y_q    <= y_d;
    tgt_q  <= tgt_d;
    rem_q  <= rem_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    sel_q  <= sel_d;
    code_q <= code_d;
    err_q  <= err_d;
    if (out_load) begin
      out_a_q    <= 32'(a_q);
      out_b_q    <= 32'(b_q);
      out_c_q    <= 32'(c_q);
      out_sel_q  <= sel_q;
      out_code_q <= code_q;
      out_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_code_q, out_c_q, out_b_q, out_a_q};
  assign m_axis_tuser  = {out_err_q, out_sel_q};

  // a finished result always reaches the output register
  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fdr_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready) |=> out_valid_q)
    else $error("finished result not loaded");

  // error results carry a zero ratio
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> (out_a_q == '0) && (out_b_q == '0) && (out_c_q == '0))
    else $error("error result with nonzero ratio");

  // a good result never has a zero denominator
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_err_q |-> (out_c_q != '0))
    else $error("zero denominator");

  // gcd operands stay nonzero so the loop ends
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fdr_pkg::ST_GCD) |-> (x_q != '0) && (y_q != '0))
    else $error("gcd operand hit zero");

endmodule
